// File: design/lcs_pkg.sv
// Package for the lock and condition-variable thread scheduler.
// Holds widths, call kinds, status and halt codes, and controller/datapath structs.
// No dependencies.
package lcs_pkg;

    localparam int LCS_MAX_THREADS = 16;
    localparam int LCS_MAX_LOCKS   = 8;
    localparam int LCS_MAX_CONDS   = 16;

    localparam int THREAD_W = 4;
    localparam int KEY_W    = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int HALT_W   = 2;

    localparam logic [KIND_W-1:0] K_INIT   = 3'd0;
    localparam logic [KIND_W-1:0] K_CREATE = 3'd1;
    localparam logic [KIND_W-1:0] K_LOCK   = 3'd2;
    localparam logic [KIND_W-1:0] K_UNLOCK = 3'd3;
    localparam logic [KIND_W-1:0] K_WAIT   = 3'd4;
    localparam logic [KIND_W-1:0] K_SIGNAL = 3'd5;
    localparam logic [KIND_W-1:0] K_YIELD  = 3'd6;
    localparam logic [KIND_W-1:0] K_FINISH = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNK_LOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNK_COND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic [HALT_W-1:0] HALT_RUN      = 2'd0;
    localparam logic [HALT_W-1:0] HALT_EXIT     = 2'd1;
    localparam logic [HALT_W-1:0] HALT_DEADLOCK = 2'd2;

    typedef struct packed {
        logic load;
        logic lsrch;
        logic csrch;
        logic exec;
    } lcs_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              lsrch_done;
        logic              lhit;
        logic              csrch_done;
    } lcs_stat_t;

endpackage

// File: design/lcs_if.sv
// Valid/ready channel interfaces for calls and results.
// Depends on lcs_pkg.
interface lcs_call_if import lcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [THREAD_W-1:0] thread_id;
    logic [KEY_W-1:0]    lock_id;
    logic [KEY_W-1:0]    cond_id;

    modport source (output valid, kind, thread_id, lock_id, cond_id, input ready);
    modport sink   (input valid, kind, thread_id, lock_id, cond_id, output ready);
endinterface

interface lcs_result_if import lcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [THREAD_W-1:0] running_thread;
    logic                switched;
    logic [HALT_W-1:0]   halt;

    modport source (output valid, status, running_thread, switched, halt, input ready);
    modport sink   (input valid, status, running_thread, switched, halt, output ready);
endinterface

// File: design/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/lcs_ctrl.sv
// Controller state machine: sequences search, read, execute and result phases.
// Depends on lcs_pkg.
module lcs_ctrl import lcs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      call_valid,
    output logic      call_ready,
    output logic      result_valid,
    input  logic      result_ready,
    input  lcs_stat_t stat,
    output lcs_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LSRCH = 3'd1;
    localparam logic [2:0] S_CSRCH = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign call_ready   = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && call_valid;
        cmd.lsrch  = (state_reg == S_LSRCH);
        cmd.csrch  = (state_reg == S_CSRCH);
        cmd.exec   = (state_reg == S_EXEC);
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (call_valid)
                begin
                    state_next = S_LSRCH;
                end
            end
            S_LSRCH:
            begin
                if (stat.lsrch_done)
                begin
                    if (stat.lhit && (stat.kind inside {K_WAIT, K_SIGNAL}))
                    begin
                        state_next = S_CSRCH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_CSRCH:
            begin
                if (stat.csrch_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_OUT:
            begin
                if (result_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/lcs_dp.sv
// Datapath: ready queue, lock and condition tables, per-lock and per-condition queues.
// Depends on lcs_pkg and lcs_ram.
module lcs_dp import lcs_pkg::*; #(
    parameter int MAX_THREADS = LCS_MAX_THREADS,
    parameter int MAX_LOCKS   = LCS_MAX_LOCKS,
    parameter int MAX_CONDS   = LCS_MAX_CONDS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lcs_cmd_t            cmd,
    output lcs_stat_t           stat,
    input  logic [KIND_W-1:0]   kind,
    input  logic [THREAD_W-1:0] thread_id,
    input  logic [KEY_W-1:0]    lock_id,
    input  logic [KEY_W-1:0]    cond_id,
    output logic [STATUS_W-1:0] status,
    output logic [THREAD_W-1:0] running_thread,
    output logic                switched,
    output logic [HALT_W-1:0]   halt
);

    localparam int PW   = $clog2(MAX_THREADS);
    localparam int CNTW = $clog2(MAX_THREADS + 1);
    localparam int LW   = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
    localparam int CW   = (MAX_CONDS > 1) ? $clog2(MAX_CONDS) : 1;
    localparam int BD   = MAX_LOCKS * MAX_THREADS;
    localparam int WD   = MAX_CONDS * MAX_THREADS;
    localparam int BAW  = $clog2(BD);
    localparam int WAW  = $clog2(WD);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_THREADS);

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                               input logic [CNTW-1:0] n);
        logic [CNTW:0] s;
        s = (CNTW+1)'(p) + (CNTW+1)'(n);
        if (s >= (CNTW+1)'(MAX_THREADS))
        begin
            s = s - (CNTW+1)'(MAX_THREADS);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(MAX_THREADS - 1) : p - PW'(1);
    endfunction

    // Captured call
    logic [KIND_W-1:0]   kind_reg;
    logic [THREAD_W-1:0] tid_reg;
    logic [KEY_W-1:0]    lkey_reg;
    logic [KEY_W-1:0]    ckey_reg;

    // Search state
    logic [LW-1:0] lidx_reg, lfree_reg, li_reg;
    logic          lfree_vld_reg, lfound_reg, lfree_ok_reg;
    logic [CW-1:0] cidx_reg, cfree_reg, ci_reg;
    logic          cfree_vld_reg, cfound_reg, cfree_ok_reg;

    // Scheduler state
    logic [THREAD_W-1:0] running_reg, running_next;
    logic [PW-1:0]       rhead_reg, rhead_next;
    logic [CNTW-1:0]     rcount_reg, rcount_next;

    logic [KEY_W-1:0]    lock_key_reg   [MAX_LOCKS];
    logic [KEY_W-1:0]    lock_key_next  [MAX_LOCKS];
    logic                lock_valid_reg [MAX_LOCKS];
    logic                lock_valid_next[MAX_LOCKS];
    logic                lock_busy_reg  [MAX_LOCKS];
    logic                lock_busy_next [MAX_LOCKS];
    logic [THREAD_W-1:0] lock_owner_reg [MAX_LOCKS];
    logic [THREAD_W-1:0] lock_owner_next[MAX_LOCKS];
    logic [PW-1:0]       bhead_reg      [MAX_LOCKS];
    logic [PW-1:0]       bhead_next     [MAX_LOCKS];
    logic [CNTW-1:0]     bcount_reg     [MAX_LOCKS];
    logic [CNTW-1:0]     bcount_next    [MAX_LOCKS];

    logic                cond_valid_reg [MAX_CONDS];
    logic                cond_valid_next[MAX_CONDS];
    logic [LW-1:0]       cond_lock_reg  [MAX_CONDS];
    logic [LW-1:0]       cond_lock_next [MAX_CONDS];
    logic [KEY_W-1:0]    cond_key_reg   [MAX_CONDS];
    logic [KEY_W-1:0]    cond_key_next  [MAX_CONDS];
    logic [PW-1:0]       chead_reg      [MAX_CONDS];
    logic [PW-1:0]       chead_next     [MAX_CONDS];
    logic [CNTW-1:0]     ccount_reg     [MAX_CONDS];
    logic [CNTW-1:0]     ccount_next    [MAX_CONDS];

    // Result register
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [THREAD_W-1:0] run_out_reg;
    logic                switched_reg;
    logic [HALT_W-1:0]   halt_reg, halt_next;

    // Queue memories
    logic                rq_we, bq_we, wq_we;
    logic [PW-1:0]       rq_waddr;
    logic [BAW-1:0]      bq_waddr, bq_raddr;
    logic [WAW-1:0]      wq_waddr, wq_raddr;
    logic [THREAD_W-1:0] rq_wdata, bq_wdata, wq_wdata;
    logic [THREAD_W-1:0] rq_rdata, bq_rdata, wq_rdata;

    // Search compares
    logic lhit, llast, lfree_now, cmatch, clast, cfree_now;

    // Execute temporaries
    logic            busy_c, pushed;
    logic [CNTW-1:0] bcnt_c, wcnt_c;
    logic [CNTW:0]   rc1;

    assign lhit      = lock_valid_reg[lidx_reg] && (lock_key_reg[lidx_reg] == lkey_reg);
    assign llast     = (lidx_reg == LW'(MAX_LOCKS - 1));
    assign lfree_now = !lock_valid_reg[lidx_reg];
    assign cmatch    = cond_valid_reg[cidx_reg] && (cond_lock_reg[cidx_reg] == li_reg)
                       && (cond_key_reg[cidx_reg] == ckey_reg);
    assign clast     = (cidx_reg == CW'(MAX_CONDS - 1));
    assign cfree_now = !cond_valid_reg[cidx_reg];

    assign stat.kind       = kind_reg;
    assign stat.lsrch_done = lhit || llast;
    assign stat.lhit       = lhit;
    assign stat.csrch_done = cmatch || clast;

    assign bq_raddr = BAW'(int'(li_reg) * MAX_THREADS + int'(bhead_reg[li_reg]));
    assign wq_raddr = WAW'(int'(ci_reg) * MAX_THREADS + int'(chead_reg[ci_reg]));

    lcs_ram #(.WIDTH(THREAD_W), .DEPTH(MAX_THREADS)) u_ready_ram (
        .clk(clk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
        .raddr(rhead_reg), .rdata(rq_rdata)
    );

    lcs_ram #(.WIDTH(THREAD_W), .DEPTH(BD)) u_blocked_ram (
        .clk(clk), .we(bq_we), .waddr(bq_waddr), .wdata(bq_wdata),
        .raddr(bq_raddr), .rdata(bq_rdata)
    );

    lcs_ram #(.WIDTH(THREAD_W), .DEPTH(WD)) u_wait_ram (
        .clk(clk), .we(wq_we), .waddr(wq_waddr), .wdata(wq_wdata),
        .raddr(wq_raddr), .rdata(wq_rdata)
    );

    always_comb
    begin
        running_next    = running_reg;
        rhead_next      = rhead_reg;
        rcount_next     = rcount_reg;
        lock_key_next   = lock_key_reg;
        lock_valid_next = lock_valid_reg;
        lock_busy_next  = lock_busy_reg;
        lock_owner_next = lock_owner_reg;
        bhead_next      = bhead_reg;
        bcount_next     = bcount_reg;
        cond_valid_next = cond_valid_reg;
        cond_lock_next  = cond_lock_reg;
        cond_key_next   = cond_key_reg;
        chead_next      = chead_reg;
        ccount_next     = ccount_reg;
        status_next     = ST_OK;
        halt_next       = HALT_RUN;
        rq_we    = 1'b0;
        rq_waddr = wrap_add(rhead_reg, rcount_reg);
        rq_wdata = running_reg;
        bq_we    = 1'b0;
        bq_waddr = bq_raddr;
        bq_wdata = running_reg;
        wq_we    = 1'b0;
        wq_waddr = wq_raddr;
        wq_wdata = running_reg;
        busy_c   = lfound_reg && lock_busy_reg[li_reg];
        bcnt_c   = lfound_reg ? bcount_reg[li_reg] : '0;
        wcnt_c   = cfound_reg ? ccount_reg[ci_reg] : '0;
        pushed   = 1'b0;
        rc1      = (CNTW+1)'(rcount_reg);

        if (cmd.exec)
        begin
            case (kind_reg)
                K_INIT:
                begin
                    running_next = tid_reg;
                    rhead_next   = '0;
                    rcount_next  = '0;
                    for (int i = 0; i < MAX_LOCKS; i++)
                    begin
                        lock_valid_next[i] = 1'b0;
                        lock_busy_next[i]  = 1'b0;
                        lock_owner_next[i] = '0;
                        bhead_next[i]      = '0;
                        bcount_next[i]     = '0;
                    end
                    for (int i = 0; i < MAX_CONDS; i++)
                    begin
                        cond_valid_next[i] = 1'b0;
                        chead_next[i]      = '0;
                        ccount_next[i]     = '0;
                    end
                end
                K_CREATE:
                begin
                    if (rcount_reg == FULL_CNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        rq_we       = 1'b1;
                        rq_wdata    = tid_reg;
                        rcount_next = rcount_reg + CNTW'(1);
                    end
                end
                K_LOCK:
                begin
                    if (!lfound_reg && !lfree_ok_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (!busy_c)
                    begin
                        lock_valid_next[li_reg] = 1'b1;
                        lock_key_next[li_reg]   = lkey_reg;
                        lock_busy_next[li_reg]  = 1'b1;
                        lock_owner_next[li_reg] = running_reg;
                        bcount_next[li_reg]     = bcnt_c;
                    end
                    else if (bcnt_c == FULL_CNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        bq_we    = 1'b1;
                        bq_waddr = BAW'(int'(li_reg) * MAX_THREADS
                                        + int'(wrap_add(bhead_reg[li_reg], bcnt_c)));
                        bcount_next[li_reg] = bcnt_c + CNTW'(1);
                        if (rcount_reg == '0)
                        begin
                            halt_next = HALT_DEADLOCK;
                        end
                        else
                        begin
                            running_next = rq_rdata;
                            rhead_next   = wrap_add(rhead_reg, CNTW'(1));
                            rcount_next  = rcount_reg - CNTW'(1);
                        end
                    end
                end
                K_UNLOCK, K_WAIT:
                begin
                    if (!lfound_reg)
                    begin
                        status_next = ST_UNK_LOCK;
                    end
                    else if ((kind_reg == K_WAIT) && !cfound_reg && !cfree_ok_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else if ((kind_reg == K_WAIT) && (wcnt_c == FULL_CNT))
                    begin
                        status_next = ST_FULL;
                    end
                    else if (busy_c && (bcnt_c != '0) && (rcount_reg == FULL_CNT))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        if (kind_reg == K_WAIT)
                        begin
                            cond_valid_next[ci_reg] = 1'b1;
                            cond_lock_next[ci_reg]  = li_reg;
                            cond_key_next[ci_reg]   = ckey_reg;
                            wq_we    = 1'b1;
                            wq_waddr = WAW'(int'(ci_reg) * MAX_THREADS
                                            + int'(wrap_add(chead_reg[ci_reg], wcnt_c)));
                            ccount_next[ci_reg] = wcnt_c + CNTW'(1);
                        end
                        // Release: hand the lock to the blocked head if any
                        if (busy_c)
                        begin
                            if (bcnt_c != '0)
                            begin
                                lock_owner_next[li_reg] = bq_rdata;
                                bhead_next[li_reg]  = wrap_add(bhead_reg[li_reg], CNTW'(1));
                                bcount_next[li_reg] = bcnt_c - CNTW'(1);
                                rq_we    = 1'b1;
                                rq_wdata = bq_rdata;
                                pushed   = 1'b1;
                            end
                            else
                            begin
                                lock_busy_next[li_reg] = 1'b0;
                            end
                        end
                        rc1 = (CNTW+1)'(rcount_reg) + (CNTW+1)'(pushed);
                        rcount_next = rc1[CNTW-1:0];
                        if (kind_reg == K_WAIT)
                        begin
                            if (rc1 == '0)
                            begin
                                halt_next = HALT_DEADLOCK;
                            end
                            else
                            begin
                                running_next = (rcount_reg == '0) ? bq_rdata : rq_rdata;
                                rhead_next   = wrap_add(rhead_reg, CNTW'(1));
                                rcount_next  = CNTW'(rc1 - (CNTW+1)'(1));
                            end
                        end
                    end
                end
                K_SIGNAL:
                begin
                    if (!lfound_reg)
                    begin
                        status_next = ST_UNK_LOCK;
                    end
                    else if (!cfound_reg)
                    begin
                        status_next = ST_UNK_COND;
                    end
                    else if (wcnt_c == '0)
                    begin
                        status_next = ST_OK;
                    end
                    else if (!busy_c)
                    begin
                        if (rcount_reg == FULL_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            chead_next[ci_reg]  = wrap_add(chead_reg[ci_reg], CNTW'(1));
                            ccount_next[ci_reg] = wcnt_c - CNTW'(1);
                            lock_busy_next[li_reg]  = 1'b1;
                            lock_owner_next[li_reg] = wq_rdata;
                            rq_we       = 1'b1;
                            rq_wdata    = wq_rdata;
                            rcount_next = rcount_reg + CNTW'(1);
                        end
                    end
                    else if (bcnt_c == FULL_CNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        chead_next[ci_reg]  = wrap_add(chead_reg[ci_reg], CNTW'(1));
                        ccount_next[ci_reg] = wcnt_c - CNTW'(1);
                        bhead_next[li_reg]  = wrap_dec(bhead_reg[li_reg]);
                        bcount_next[li_reg] = bcnt_c + CNTW'(1);
                        bq_we    = 1'b1;
                        bq_waddr = BAW'(int'(li_reg) * MAX_THREADS
                                        + int'(wrap_dec(bhead_reg[li_reg])));
                        bq_wdata = wq_rdata;
                    end
                end
                K_YIELD:
                begin
                    if (rcount_reg != '0)
                    begin
                        running_next = rq_rdata;
                        rhead_next   = wrap_add(rhead_reg, CNTW'(1));
                        rq_we        = 1'b1;
                    end
                end
                default:
                begin
                    if (rcount_reg == '0)
                    begin
                        halt_next = HALT_EXIT;
                    end
                    else
                    begin
                        running_next = rq_rdata;
                        rhead_next   = wrap_add(rhead_reg, CNTW'(1));
                        rcount_next  = rcount_reg - CNTW'(1);
                    end
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            tid_reg  <= thread_id;
            lkey_reg <= lock_id;
            ckey_reg <= cond_id;
        end
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            halt_reg     <= halt_next;
            run_out_reg  <= running_next;
            switched_reg <= (running_next != running_reg);
        end
        lock_key_reg  <= lock_key_next;
        cond_key_reg  <= cond_key_next;
        cond_lock_reg <= cond_lock_next;
        if (cmd.lsrch && stat.lsrch_done)
        begin
            li_reg <= lhit ? lidx_reg : (lfree_vld_reg ? lfree_reg : lidx_reg);
        end
        else if (cmd.lsrch && lfree_now && !lfree_vld_reg)
        begin
            lfree_reg <= lidx_reg;
        end
        if (cmd.csrch && stat.csrch_done)
        begin
            ci_reg <= cmatch ? cidx_reg : (cfree_vld_reg ? cfree_reg : cidx_reg);
        end
        else if (cmd.csrch && cfree_now && !cfree_vld_reg)
        begin
            cfree_reg <= cidx_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            rhead_reg     <= '0;
            rcount_reg    <= '0;
            lidx_reg      <= '0;
            cidx_reg      <= '0;
            lfree_vld_reg <= 1'b0;
            cfree_vld_reg <= 1'b0;
            lfound_reg    <= 1'b0;
            lfree_ok_reg  <= 1'b0;
            cfound_reg    <= 1'b0;
            cfree_ok_reg  <= 1'b0;
            for (int i = 0; i < MAX_LOCKS; i++)
            begin
                lock_valid_reg[i] <= 1'b0;
                lock_busy_reg[i]  <= 1'b0;
                lock_owner_reg[i] <= '0;
                bhead_reg[i]      <= '0;
                bcount_reg[i]     <= '0;
            end
            for (int i = 0; i < MAX_CONDS; i++)
            begin
                cond_valid_reg[i] <= 1'b0;
                chead_reg[i]      <= '0;
                ccount_reg[i]     <= '0;
            end
        end
        else
        begin
            running_reg    <= running_next;
            rhead_reg      <= rhead_next;
            rcount_reg     <= rcount_next;
            lock_valid_reg <= lock_valid_next;
            lock_busy_reg  <= lock_busy_next;
            lock_owner_reg <= lock_owner_next;
            bhead_reg      <= bhead_next;
            bcount_reg     <= bcount_next;
            cond_valid_reg <= cond_valid_next;
            chead_reg      <= chead_next;
            ccount_reg     <= ccount_next;
            if (cmd.load)
            begin
                lidx_reg      <= '0;
                cidx_reg      <= '0;
                lfree_vld_reg <= 1'b0;
                cfree_vld_reg <= 1'b0;
                lfound_reg    <= 1'b0;
                cfound_reg    <= 1'b0;
            end
            if (cmd.lsrch)
            begin
                if (stat.lsrch_done)
                begin
                    lfound_reg   <= lhit;
                    lfree_ok_reg <= lhit || lfree_vld_reg || lfree_now;
                end
                else
                begin
                    lidx_reg <= lidx_reg + LW'(1);
                    if (lfree_now)
                    begin
                        lfree_vld_reg <= 1'b1;
                    end
                end
            end
            if (cmd.csrch)
            begin
                if (stat.csrch_done)
                begin
                    cfound_reg   <= cmatch;
                    cfree_ok_reg <= cmatch || cfree_vld_reg || cfree_now;
                end
                else
                begin
                    cidx_reg <= cidx_reg + CW'(1);
                    if (cfree_now)
                    begin
                        cfree_vld_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign status         = status_reg;
    assign running_thread = run_out_reg;
    assign switched       = switched_reg;
    assign halt           = halt_reg;

endmodule

// File: design/lock_condvar_thread_scheduler.sv
// Top level of the lock and condition-variable thread scheduler.
// Depends on lcs_pkg, lcs_if, lcs_ctrl, lcs_dp.
//
// Usage:
//   call   - sink channel; one word is one call of the running thread
//            (kind, thread_id, lock_id, cond_id).
//   result - source channel; one word per call (status, running_thread,
//            switched, halt).
// Sequence: after a call is accepted, a lock table scan (stops at the first
// hit), for wait and signal with a known lock a condition table scan, then a
// queue-read state and an execute state. The result word is presented in the
// following cycle. The next call can be taken in the cycle after the result
// leaves.
// One call is processed at a time; call.ready is high only when the block
// is idle.
// Reset: empties the ready queue, invalidates every lock and condition
// entry and sets the running thread to 0. Queue memories are not cleared;
// entries are read only below their fill counts.
// Stall: the result word is held in its register until result.ready; no new
// call is taken meanwhile.
module lock_condvar_thread_scheduler import lcs_pkg::*; #(
    parameter int MAX_THREADS = LCS_MAX_THREADS,
    parameter int MAX_LOCKS   = LCS_MAX_LOCKS,
    parameter int MAX_CONDS   = LCS_MAX_CONDS
) (
    input logic         clk,
    input logic         rst_n,
    lcs_call_if.sink    call,
    lcs_result_if.source result
);

    lcs_cmd_t  cmd;
    lcs_stat_t stat;

    // Sequence the phases of one call
    lcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .call_valid   (call.valid),
        .call_ready   (call.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Hold the tables and queues and execute the call
    lcs_dp #(
        .MAX_THREADS (MAX_THREADS),
        .MAX_LOCKS   (MAX_LOCKS),
        .MAX_CONDS   (MAX_CONDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (call.kind),
        .thread_id      (call.thread_id),
        .lock_id        (call.lock_id),
        .cond_id        (call.cond_id),
        .status         (result.status),
        .running_thread (result.running_thread),
        .switched       (result.switched),
        .halt           (result.halt)
    );

endmodule

// File: design/lcs_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on lcs_pkg and lcs_if.
module lcs_checker import lcs_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    lcs_call_if.sink     call,
    lcs_result_if.source result
);

    // One call in flight: never ready for a call while a result is shown
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(call.ready && result.valid))
        else $error("call taken while result pending");

    // A result never appears in the cycle right after a call is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (call.valid && call.ready) |=> !result.valid)
        else $error("result too early");

    // A halt leaves the running thread in place
    a_halt_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.halt != HALT_RUN)) |-> !result.switched)
        else $error("switch reported on halt");

    // Stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=>
        (result.valid && $stable(result.status) && $stable(result.running_thread)
         && $stable(result.halt) && $stable(result.switched)))
        else $error("result changed while stalled");

endmodule

bind lock_condvar_thread_scheduler lcs_checker u_lcs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .call   (call),
    .result (result)
);

// File: bench/lcs_sched_scoreboard.sv
// Scheduler call predictor and result checker for the thread scheduler bench.
// Depends on lcs_pkg; compiled before the bench top module.
`timescale 1ns / 1ps

class lcs_sched_scoreboard;
    typedef struct packed {
        logic [lcs_pkg::STATUS_W-1:0] status;
        logic [lcs_pkg::THREAD_W-1:0] running_thread;
        logic                         switched;
        logic [lcs_pkg::HALT_W-1:0]   halt;
    } sched_word_t;

    localparam int NT = lcs_pkg::LCS_MAX_THREADS;
    localparam int NL = lcs_pkg::LCS_MAX_LOCKS;
    localparam int NC = lcs_pkg::LCS_MAX_CONDS;

    logic [3:0]  cur_thread;
    logic [3:0]  ready_q[$];
    logic [31:0] lk_key[NL];
    bit          lk_valid[NL];
    bit          lk_busy[NL];
    logic [3:0]  lk_owner[NL];
    logic [3:0]  lk_blocked[NL][$];
    bit          cv_valid[NC];
    int          cv_lock[NC];
    logic [31:0] cv_key[NC];
    logic [3:0]  cv_waiters[NC][$];

    sched_word_t pending[$];
    int          n_errors;
    int          n_checked;
    int          n_halts;
    int          n_full;

    function new();
        clear_all(4'd0);
        n_errors = 0;
        n_checked = 0;
        n_halts = 0;
        n_full = 0;
    endfunction

    function void clear_all(logic [3:0] tid);
        cur_thread = tid;
        ready_q.delete();
        for (int i = 0; i < NL; i++)
        begin
            lk_valid[i] = 0;
            lk_busy[i] = 0;
            lk_owner[i] = 0;
            lk_key[i] = 0;
            lk_blocked[i].delete();
        end
        for (int i = 0; i < NC; i++)
        begin
            cv_valid[i] = 0;
            cv_lock[i] = 0;
            cv_key[i] = 0;
            cv_waiters[i].delete();
        end
    endfunction

    function int find_lock(logic [31:0] key);
        for (int i = 0; i < NL; i++)
            if (lk_valid[i] && lk_key[i] == key)
                return i;
        return -1;
    endfunction

    function int find_cond(int li, logic [31:0] key);
        for (int i = 0; i < NC; i++)
            if (cv_valid[i] && cv_lock[i] == li && cv_key[i] == key)
                return i;
        return -1;
    endfunction

    function int free_cond();
        for (int i = 0; i < NC; i++)
            if (!cv_valid[i])
                return i;
        return -1;
    endfunction

    function bit dispatch();
        if (ready_q.size() == 0)
            return 0;
        cur_thread = ready_q.pop_front();
        return 1;
    endfunction

    function void release_lock(int li);
        if (!lk_busy[li])
            return;
        lk_busy[li] = 0;
        if (lk_blocked[li].size() > 0)
        begin
            lk_owner[li] = lk_blocked[li].pop_front();
            lk_busy[li] = 1;
            ready_q.push_back(lk_owner[li]);
        end
    endfunction

    // Apply one accepted call and queue the word it must produce.
    function void note_call(logic [2:0] kind, logic [3:0] tid, logic [31:0] lkey,
                            logic [31:0] ckey);
        logic [3:0]  prev;
        sched_word_t w;
        int          li;
        int          ci;
        prev = cur_thread;
        w = '0;
        case (kind)
            lcs_pkg::K_INIT:
                clear_all(tid);
            lcs_pkg::K_CREATE:
                if (ready_q.size() >= NT) w.status = lcs_pkg::ST_FULL;
                else ready_q.push_back(tid);
            lcs_pkg::K_LOCK:
            begin
                li = find_lock(lkey);
                if (li < 0)
                begin
                    for (int i = NL - 1; i >= 0; i--)
                        if (!lk_valid[i]) li = i;
                    if (li >= 0)
                    begin
                        lk_valid[li] = 1;
                        lk_key[li] = lkey;
                        lk_busy[li] = 0;
                        lk_owner[li] = cur_thread;
                        lk_blocked[li].delete();
                    end
                end
                if (li < 0)
                    w.status = lcs_pkg::ST_FULL;
                else if (!lk_busy[li])
                begin
                    lk_busy[li] = 1;
                    lk_owner[li] = cur_thread;
                end
                else if (lk_blocked[li].size() >= NT)
                    w.status = lcs_pkg::ST_FULL;
                else
                begin
                    lk_blocked[li].push_back(cur_thread);
                    if (!dispatch()) w.halt = lcs_pkg::HALT_DEADLOCK;
                end
            end
            lcs_pkg::K_UNLOCK:
            begin
                li = find_lock(lkey);
                if (li < 0)
                    w.status = lcs_pkg::ST_UNK_LOCK;
                else if (lk_busy[li] && lk_blocked[li].size() > 0 && ready_q.size() >= NT)
                    w.status = lcs_pkg::ST_FULL;
                else
                    release_lock(li);
            end
            lcs_pkg::K_WAIT:
            begin
                li = find_lock(lkey);
                ci = (li < 0) ? -1 : find_cond(li, ckey);
                if (li < 0)
                    w.status = lcs_pkg::ST_UNK_LOCK;
                else if (ci < 0 && free_cond() < 0)
                    w.status = lcs_pkg::ST_FULL;
                else if (ci >= 0 && cv_waiters[ci].size() >= NT)
                    w.status = lcs_pkg::ST_FULL;
                else if (lk_busy[li] && lk_blocked[li].size() > 0 && ready_q.size() >= NT)
                    w.status = lcs_pkg::ST_FULL;
                else
                begin
                    if (ci < 0)
                    begin
                        ci = free_cond();
                        cv_valid[ci] = 1;
                        cv_lock[ci] = li;
                        cv_key[ci] = ckey;
                        cv_waiters[ci].delete();
                    end
                    cv_waiters[ci].push_back(cur_thread);
                    release_lock(li);
                    if (!dispatch()) w.halt = lcs_pkg::HALT_DEADLOCK;
                end
            end
            lcs_pkg::K_SIGNAL:
            begin
                li = find_lock(lkey);
                ci = (li < 0) ? -1 : find_cond(li, ckey);
                if (li < 0)
                    w.status = lcs_pkg::ST_UNK_LOCK;
                else if (ci < 0)
                    w.status = lcs_pkg::ST_UNK_COND;
                else if (cv_waiters[ci].size() == 0)
                    w.status = lcs_pkg::ST_OK;
                else if (!lk_busy[li])
                begin
                    if (ready_q.size() >= NT)
                        w.status = lcs_pkg::ST_FULL;
                    else
                    begin
                        lk_owner[li] = cv_waiters[ci].pop_front();
                        lk_busy[li] = 1;
                        ready_q.push_back(lk_owner[li]);
                    end
                end
                else if (lk_blocked[li].size() >= NT)
                    w.status = lcs_pkg::ST_FULL;
                else
                    lk_blocked[li].push_front(cv_waiters[ci].pop_front());
            end
            lcs_pkg::K_YIELD:
                if (ready_q.size() > 0)
                begin
                    void'(dispatch());
                    ready_q.push_back(prev);
                end
            default:
                if (!dispatch()) w.halt = lcs_pkg::HALT_EXIT;
        endcase
        w.running_thread = cur_thread;
        w.switched = (cur_thread != prev);
        if (w.halt != lcs_pkg::HALT_RUN) n_halts++;
        if (w.status == lcs_pkg::ST_FULL) n_full++;
        pending.push_back(w);
    endfunction

    // Compare one result word with the oldest prediction.
    function void check_word(sched_word_t got);
        sched_word_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: result word with nothing expected, got %h", $time, got);
            n_errors++;
            return;
        end
        want = pending.pop_front();
        n_checked++;
        if (got.status !== want.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            n_errors++;
        end
        if (got.running_thread !== want.running_thread)
        begin
            $display("%0t: running_thread expected %0d actual %0d", $time,
                     want.running_thread, got.running_thread);
            n_errors++;
        end
        if (got.switched !== want.switched)
        begin
            $display("%0t: switched expected %0d actual %0d", $time, want.switched,
                     got.switched);
            n_errors++;
        end
        if (got.halt !== want.halt)
        begin
            $display("%0t: halt expected %0d actual %0d", $time, want.halt, got.halt);
            n_errors++;
        end
    endfunction
endclass

// File: bench/tb_lock_condvar_thread_scheduler.sv
// Bench top for lock_condvar_thread_scheduler: drives calls, checks result words.
// Depends on lcs_pkg, lcs_if, the scheduler RTL and lcs_sched_scoreboard.
`timescale 1ns / 1ps

module tb_lock_condvar_thread_scheduler;
    import lcs_pkg::*;

    localparam int RANDOM_CALLS = 1150;
    // Idle cycles allowed before the run is declared hung: enough for the longest
    // call with full table scans, plus the longest sink stall and sender gap.
    localparam int HANG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    lcs_call_if   call ();
    lcs_result_if result ();

    lock_condvar_thread_scheduler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .call   (call),
        .result (result)
    );

    lcs_sched_scoreboard sched_model;
    int  idle_cycles = 0;
    int  n_sent;
    bit  hung;
    int  kind_seen[8];

    // Small key pools so that calls hit existing table entries most of the time.
    logic [31:0] lock_pool[6];
    logic [31:0] cond_pool[4];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        call.valid = 1'b0;
        call.kind = K_INIT;
        call.thread_id = '0;
        call.lock_id = '0;
        call.cond_id = '0;
        result.ready = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Sample both channels at the rising edge; the model advances on accept.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (call.valid && call.ready)
            begin
                sched_model.note_call(call.kind, call.thread_id, call.lock_id, call.cond_id);
                kind_seen[call.kind]++;
            end
            if (result.valid && result.ready)
            begin
                sched_model.check_word({result.status, result.running_thread,
                                        result.switched, result.halt});
            end
            if ((call.valid && call.ready) || (result.valid && result.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall in its own rhythm; some stretches never stall.
    initial
    begin : sink_stall
        int mode;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60))
            begin
                @(negedge clk);
                case (mode)
                    0: result.ready <= 1'b1;
                    1: result.ready <= ($urandom_range(0, 3) != 0);
                    2: result.ready <= ($urandom_range(0, 1) != 0);
                    default: result.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Hold one call word until it is accepted, then drop valid.
    task automatic send_call(logic [2:0] kind, logic [3:0] tid, logic [31:0] lkey,
                             logic [31:0] ckey);
        call.kind = kind;
        call.thread_id = tid;
        call.lock_id = lkey;
        call.cond_id = ckey;
        call.valid = 1'b1;
        do
            @(posedge clk);
        while (!(call.ready === 1'b1));
        @(negedge clk);
        call.valid = 1'b0;
        n_sent++;
    endtask

    // Insert an idle gap between bursts of calls.
    task automatic sender_gap();
        repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    // Weighted random call: mostly well-formed use of the pooled keys, some noise.
    task automatic send_random_call();
        logic [2:0]  kind;
        logic [31:0] lkey;
        logic [31:0] ckey;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) kind = K_INIT;
        else if (pick < 20) kind = K_CREATE;
        else if (pick < 40) kind = K_LOCK;
        else if (pick < 58) kind = K_UNLOCK;
        else if (pick < 72) kind = K_WAIT;
        else if (pick < 86) kind = K_SIGNAL;
        else if (pick < 94) kind = K_YIELD;
        else kind = K_FINISH;
        lkey = ($urandom_range(0, 19) == 0) ? $urandom() : lock_pool[$urandom_range(0, 5)];
        ckey = ($urandom_range(0, 19) == 0) ? $urandom() : cond_pool[$urandom_range(0, 3)];
        send_call(kind, 4'($urandom_range(0, 15)), lkey, ckey);
    endtask

    initial
    begin : stimulus
        int burst;
        sched_model = new();
        n_sent = 0;
        hung = 0;
        lock_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h5A5A_A5A5, 32'h1234_5678};
        cond_pool = '{32'h0, 32'hFFFF_FFFF, 32'h7, 32'hA5A5_5A5A};
        call.valid = 1'b0;
        @(posedge rst_n);
        @(negedge clk);

        // Directed: each call kind, key extremes, and the corner cases.
        send_call(K_UNLOCK, 4'd0, 32'hFFFF_FFFF, 32'h0);        // unknown lock
        send_call(K_INIT, 4'd15, 32'h0, 32'h0);
        send_call(K_YIELD, 4'd0, 32'h0, 32'h0);                 // nothing ready
        send_call(K_CREATE, 4'd3, 32'h0, 32'h0);
        send_call(K_LOCK, 4'd0, 32'hFFFF_FFFF, 32'h0);
        send_call(K_LOCK, 4'd0, 32'hFFFF_FFFF, 32'h0);          // owner relocks, blocks
        send_call(K_SIGNAL, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // unknown condition
        send_call(K_WAIT, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // blocked owner gets the lock
        send_call(K_WAIT, 4'd0, 32'h0, 32'h0);                  // unknown lock
        send_call(K_INIT, 4'd0, 32'h0, 32'h0);
        send_call(K_CREATE, 4'd9, 32'h0, 32'h0);
        send_call(K_LOCK, 4'd0, 32'h0, 32'h0);
        send_call(K_WAIT, 4'd0, 32'h0, 32'hFFFF_FFFF);          // thread 9 runs
        send_call(K_SIGNAL, 4'd0, 32'h0, 32'h0);                // unknown condition
        send_call(K_SIGNAL, 4'd0, 32'h0, 32'hFFFF_FFFF);        // lock free: waiter owns
        send_call(K_SIGNAL, 4'd0, 32'h0, 32'hFFFF_FFFF);        // empty wait queue
        send_call(K_FINISH, 4'd0, 32'h0, 32'h0);
        send_call(K_FINISH, 4'd0, 32'h0, 32'h0);                // nothing ready: exit
        for (int i = 0; i < 17; i++)                            // fill the ready queue
            send_call(K_CREATE, i[3:0], 32'h0, 32'h0);
        for (int i = 0; i < 9; i++)                             // overflow the lock table
            send_call(K_LOCK, 4'd0, 32'h100 + i, 32'h0);

        // Random part: bursts of calls with random gaps.
        while (n_sent < RANDOM_CALLS)
        begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++)
                send_random_call();
            if ($urandom_range(0, 3) != 0)
                sender_gap();
        end

        // Drain, then let the block settle.
        while (sched_model.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Ran %0d calls (%0d init, %0d lock, %0d wait, %0d signal); %0d halts, %0d full.",
                 n_sent, kind_seen[K_INIT], kind_seen[K_LOCK], kind_seen[K_WAIT],
                 kind_seen[K_SIGNAL], sched_model.n_halts, sched_model.n_full);
        $display("Checked %0d result words, %0d mismatches.", sched_model.n_checked,
                 sched_model.n_errors);
        if (sched_model.n_errors == 0 && !hung)
            $display("lock_condvar_thread_scheduler verification clean");
        else
            $display("lock_condvar_thread_scheduler verification failed");
        $finish;
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= HANG_LIMIT && !hung)
        begin
            hung = 1;
            $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("lock_condvar_thread_scheduler verification failed");
            $finish;
        end
    end
endmodule
